FILE: rtl/core/point_table_with_staleness_sweep_defines.svh
// assertion macros for the point table engine rtl
`ifndef POINT_TABLE_WITH_STALENESS_SWEEP_DEFINES_SVH
`define POINT_TABLE_WITH_STALENESS_SWEEP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PTS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // table geometry
  localparam int POINTS = 1024;
  localparam int PTR_W  = $clog2(POINTS);
  localparam int CNT_W  = PTR_W + 1;

  // fixed field widths
  localparam int IDX_W     = 10;
  localparam int PIU_W     = 11;
  localparam int FOUND_W   = 11;
  localparam int WORD_W    = 64;
  localparam int WCNT_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [PIU_W-1:0] PIU_RESET = 11'd1024;
  localparam logic [1:0]       VT_UNKNOWN = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINTS_IN_USE,
    REG_TIMEOUT_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_WRITE,
    REQ_READ,
    REQ_SWEEP,
    REQ_ACCESS
  } req_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_BAD_INDEX,
    STS_READ_ONLY
  } status_t;

  typedef enum logic [1:0] {
    Q_INITIAL,
    Q_GOOD,
    Q_TIMEOUT
  } quality_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP,
    ST_SWEEP_END
  } state_t;

  // per-point entry of the cleared memory
  typedef struct packed {
    logic [1:0]        vtype;
    logic [WORD_W-1:0] stamp;
    quality_t          quality;
    logic              ro;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    meta_t            wr_data;
    logic [PTR_W-1:0] rd_addr;
  } meta_cmd_t;

  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [PTR_W-1:0]  rd_addr;
  } value_cmd_t;

  typedef struct packed {
    status_t             status;
    logic [1:0]          rtype;
    logic [WORD_W-1:0]   rvalue;
    logic [WORD_W-1:0]   rtime;
    quality_t            rquality;
    logic                ro;
    logic [FOUND_W-1:0]  found;
    logic [WCNT_W-1:0]   writes;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/pts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/pts_engine.sv
`timescale 1ns / 1ps
`default_nettype none

`include "point_table_with_staleness_sweep_defines.svh"

module pts_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    req_type,
  input  wire logic [pts_pkg::IDX_W-1:0]     point_index,
  input  wire logic [1:0]                    value_type,
  input  wire logic [pts_pkg::WORD_W-1:0]    value_word,
  input  wire logic                          access_read_only,
  input  wire logic [pts_pkg::WORD_W-1:0]    current_time,
  // configuration
  input  wire logic [pts_pkg::PIU_W-1:0]     points_in_use,
  input  wire logic [pts_pkg::WORD_W-1:0]    timeout_limit,
  // memories
  output pts_pkg::meta_cmd_t                 meta_cmd,
  input  wire pts_pkg::meta_t                meta_rdata,
  output pts_pkg::value_cmd_t                value_cmd,
  input  wire logic [pts_pkg::WORD_W-1:0]    value_rdata,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pts_pkg::result_t                   res
);

  pts_pkg::state_t                 state, state_next;
  pts_pkg::req_t                   req, req_next;
  logic [pts_pkg::IDX_W-1:0]       req_idx, req_idx_next;
  logic [1:0]                      req_vtype, req_vtype_next;
  logic [pts_pkg::WORD_W-1:0]      req_word, req_word_next;
  logic                            req_ro, req_ro_next;
  logic [pts_pkg::WORD_W-1:0]      req_now, req_now_next;
  logic [pts_pkg::CNT_W-1:0]       clear_addr, clear_addr_next;
  logic [pts_pkg::CNT_W-1:0]       sweep_rd, sweep_rd_next;
  logic                            eval_vld, eval_vld_next;
  logic [pts_pkg::PTR_W-1:0]       eval_addr, eval_addr_next;
  logic [pts_pkg::CNT_W-1:0]       found, found_next;
  logic [pts_pkg::WCNT_W-1:0]      write_count, write_count_next;
  logic                            load_res;
  pts_pkg::result_t                res_new;
  logic                            out_free;
  logic [pts_pkg::CNT_W-1:0]       lim;
  logic                            idx_ok;
  logic [pts_pkg::PTR_W-1:0]       req_ptr;
  logic                            stale;
  logic [pts_pkg::WORD_W-1:0]      age;

  // effective number of points in use
  always_comb begin
    if (32'(points_in_use) > 32'(pts_pkg::POINTS)) begin
      lim = pts_pkg::CNT_W'(pts_pkg::POINTS);
    end else begin
      lim = pts_pkg::CNT_W'(points_in_use);
    end
  end

  assign idx_ok   = 32'(req_idx) < 32'(lim);
  assign req_ptr  = pts_pkg::PTR_W'(req_idx);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != pts_pkg::ST_IDLE);

  // staleness test on the entry read for the sweep
  assign age   = req_now - meta_rdata.stamp;
  assign stale = (meta_rdata.stamp != '0) && (meta_rdata.quality != pts_pkg::Q_TIMEOUT) &&
                 (meta_rdata.stamp < req_now) && (age > timeout_limit);

  // next state, memory commands and result
  always_comb begin
    state_next       = state;
    req_next         = req;
    req_idx_next     = req_idx;
    req_vtype_next   = req_vtype;
    req_word_next    = req_word;
    req_ro_next      = req_ro;
    req_now_next     = req_now;
    clear_addr_next  = clear_addr;
    sweep_rd_next    = sweep_rd;
    eval_vld_next    = eval_vld;
    eval_addr_next   = eval_addr;
    found_next       = found;
    write_count_next = write_count;
    load_res         = 1'b0;

    meta_cmd.wr_en    = 1'b0;
    meta_cmd.wr_addr  = req_ptr;
    meta_cmd.wr_data  = meta_rdata;
    meta_cmd.rd_addr  = req_ptr;
    value_cmd.wr_en   = 1'b0;
    value_cmd.wr_addr = req_ptr;
    value_cmd.wr_data = req_word;
    value_cmd.rd_addr = req_ptr;

    res_new        = '0;
    res_new.status = pts_pkg::STS_OK;
    res_new.writes = write_count;

    unique case (state)
      pts_pkg::ST_CLEAR: begin
        meta_cmd.wr_en   = 1'b1;
        meta_cmd.wr_addr = clear_addr[pts_pkg::PTR_W-1:0];
        meta_cmd.wr_data = '0;
        clear_addr_next  = clear_addr + 1'b1;
        if (clear_addr == pts_pkg::CNT_W'(pts_pkg::POINTS - 1)) begin
          state_next = pts_pkg::ST_IDLE;
        end
      end
      pts_pkg::ST_IDLE: begin
        meta_cmd.rd_addr  = pts_pkg::PTR_W'(point_index);
        value_cmd.rd_addr = pts_pkg::PTR_W'(point_index);
        if (in_valid) begin
          req_next       = pts_pkg::req_t'(req_type);
          req_idx_next   = point_index;
          req_vtype_next = value_type;
          req_word_next  = value_word;
          req_ro_next    = access_read_only;
          req_now_next   = current_time;
          state_next     = pts_pkg::ST_ACCESS;
        end
      end
      pts_pkg::ST_ACCESS: begin
        if (out_free) begin
          load_res   = 1'b1;
          state_next = pts_pkg::ST_IDLE;
          case (req)
            pts_pkg::REQ_WRITE: begin
              if (!idx_ok) begin
                res_new.status = pts_pkg::STS_BAD_INDEX;
              end else if (meta_rdata.ro) begin
                res_new.status = pts_pkg::STS_READ_ONLY;
              end else begin
                meta_cmd.wr_en           = 1'b1;
                meta_cmd.wr_data.vtype   = req_vtype;
                meta_cmd.wr_data.stamp   = req_now;
                meta_cmd.wr_data.quality = pts_pkg::Q_GOOD;
                meta_cmd.wr_data.ro      = 1'b0;
                value_cmd.wr_en          = (req_vtype != pts_pkg::VT_UNKNOWN);
                write_count_next         = write_count + 1'b1;
                res_new.writes           = write_count + 1'b1;
              end
            end
            pts_pkg::REQ_READ: begin
              if (!idx_ok) begin
                res_new.status = pts_pkg::STS_BAD_INDEX;
              end else begin
                res_new.rtype    = meta_rdata.vtype;
                res_new.rvalue   = value_rdata;
                res_new.rtime    = meta_rdata.stamp;
                res_new.rquality = meta_rdata.quality;
                res_new.ro       = meta_rdata.ro;
              end
            end
            pts_pkg::REQ_ACCESS: begin
              if (!idx_ok) begin
                res_new.status = pts_pkg::STS_BAD_INDEX;
              end else begin
                meta_cmd.wr_en      = 1'b1;
                meta_cmd.wr_data.ro = req_ro;
              end
            end
            pts_pkg::REQ_SWEEP: begin
              // a zero limit or zero time answers at once
              if ((timeout_limit != '0) && (req_now != '0)) begin
                load_res      = 1'b0;
                state_next    = pts_pkg::ST_SWEEP;
                sweep_rd_next = '0;
                eval_vld_next = 1'b0;
                found_next    = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pts_pkg::ST_SWEEP: begin
        // read entry k while entry k-1 is tested and written back
        meta_cmd.rd_addr = sweep_rd[pts_pkg::PTR_W-1:0];
        if (eval_vld && stale) begin
          meta_cmd.wr_en           = 1'b1;
          meta_cmd.wr_addr         = eval_addr;
          meta_cmd.wr_data.quality = pts_pkg::Q_TIMEOUT;
          found_next               = found + 1'b1;
        end
        if (sweep_rd < lim) begin
          eval_vld_next  = 1'b1;
          eval_addr_next = sweep_rd[pts_pkg::PTR_W-1:0];
          sweep_rd_next  = sweep_rd + 1'b1;
        end else begin
          eval_vld_next = 1'b0;
          if (!eval_vld) begin
            state_next = pts_pkg::ST_SWEEP_END;
          end
        end
      end
      pts_pkg::ST_SWEEP_END: begin
        if (out_free) begin
          load_res      = 1'b1;
          res_new.found = pts_pkg::FOUND_W'(found);
          state_next    = pts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pts_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pts_pkg::ST_CLEAR;
      clear_addr  <= '0;
      sweep_rd    <= '0;
      eval_vld    <= 1'b0;
      found       <= '0;
      write_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clear_addr  <= clear_addr_next;
      sweep_rd    <= sweep_rd_next;
      eval_vld    <= eval_vld_next;
      found       <= found_next;
      write_count <= write_count_next;
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    req       <= req_next;
    req_idx   <= req_idx_next;
    req_vtype <= req_vtype_next;
    req_word  <= req_word_next;
    req_ro    <= req_ro_next;
    req_now   <= req_now_next;
    eval_addr <= eval_addr_next;
    if (load_res) begin
      res <= res_new;
    end
  end

  // accepted request always goes to the table access step
  `PTS_ASSERT_NXT(a_accept_access, clk, rst, (in_valid && !in_stall), (state == pts_pkg::ST_ACCESS))

  // sweep never counts more points than it has read
  `PTS_ASSERT_IMP(a_found_bound, clk, rst, (state == pts_pkg::ST_SWEEP), (found <= sweep_rd))

  // write-back and read of the sweep never hit the same entry
  `PTS_ASSERT_IMP(a_sweep_no_overlap, clk, rst, (state == pts_pkg::ST_SWEEP && eval_vld && sweep_rd < lim), (eval_addr != sweep_rd[pts_pkg::PTR_W-1:0]))

  // write counter only moves on a write request
  `PTS_ASSERT_IMP(a_count_on_write, clk, rst, (!$past(rst) && write_count != $past(write_count)), ($past(state) == pts_pkg::ST_ACCESS && $past(req) == pts_pkg::REQ_WRITE))

endmodule

`default_nettype wire

FILE: rtl/core/point_table_with_staleness_sweep.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// request   | in_valid / in_stall  | req_type, point_index, value_type,
//           |                      | value_word, access_read_only, current_time
// result    | out_valid/ out_stall | status, read_type, read_value, read_time,
//           |                      | read_quality, read_only_flag,
//           |                      | timeouts_found, total_writes
// config    | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// write, read, set access and a skipped sweep: the request passes the access step, which
//   waits for a free result slot and sees the registered point memory read, then idle
// sweep: covers the points in use (capped at 1024), then the sweep end step returns the
//   count; one point tested and written back per cycle, then the pipe drains
// reset: a clearing pass over all 1024 points zeroes stamp, quality and access
//   marks; in_stall stays high meanwhile, config writes are taken
// a stalled result holds; the next request is taken while it waits
`timescale 1ns / 1ps
`default_nettype none

module point_table_with_staleness_sweep (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      req_type,
  input  wire logic [pts_pkg::IDX_W-1:0]       point_index,
  input  wire logic [1:0]                      value_type,
  input  wire logic [pts_pkg::WORD_W-1:0]      value_word,
  input  wire logic                            access_read_only,
  input  wire logic [pts_pkg::WORD_W-1:0]      current_time,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           status,
  output logic [1:0]                           read_type,
  output logic [pts_pkg::WORD_W-1:0]           read_value,
  output logic [pts_pkg::WORD_W-1:0]           read_time,
  output logic [1:0]                           read_quality,
  output logic                                 read_only_flag,
  output logic [pts_pkg::FOUND_W-1:0]          timeouts_found,
  output logic [pts_pkg::WCNT_W-1:0]           total_writes,
  // configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pts_pkg::WORD_W-1:0]      cfg_data
);

  logic [pts_pkg::PIU_W-1:0]  points_in_use;
  logic [pts_pkg::WORD_W-1:0] timeout_limit;
  pts_pkg::meta_cmd_t         meta_cmd;
  pts_pkg::meta_t             meta_rdata;
  pts_pkg::value_cmd_t        value_cmd;
  logic [pts_pkg::WORD_W-1:0] value_rdata;
  pts_pkg::result_t           res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= pts_pkg::PIU_RESET;
      timeout_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pts_pkg::cfg_reg_t'(cfg_index))
        pts_pkg::REG_POINTS_IN_USE: points_in_use <= cfg_data[pts_pkg::PIU_W-1:0];
        pts_pkg::REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stamp, quality, access and type per point
  pts_ram #(
    .WIDTH (pts_pkg::META_W),
    .DEPTH (pts_pkg::POINTS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_cmd.wr_en),
    .wr_addr (meta_cmd.wr_addr),
    .wr_data (meta_cmd.wr_data),
    .rd_addr (meta_cmd.rd_addr),
    .rd_data (meta_rdata)
  );

  // raw value per point
  pts_ram #(
    .WIDTH (pts_pkg::WORD_W),
    .DEPTH (pts_pkg::POINTS)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (value_cmd.wr_en),
    .wr_addr (value_cmd.wr_addr),
    .wr_data (value_cmd.wr_data),
    .rd_addr (value_cmd.rd_addr),
    .rd_data (value_rdata)
  );

  pts_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .point_index      (point_index),
    .value_type       (value_type),
    .value_word       (value_word),
    .access_read_only (access_read_only),
    .current_time     (current_time),
    .points_in_use    (points_in_use),
    .timeout_limit    (timeout_limit),
    .meta_cmd         (meta_cmd),
    .meta_rdata       (meta_rdata),
    .value_cmd        (value_cmd),
    .value_rdata      (value_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .res              (res)
  );

  // result fields
  assign status         = res.status;
  assign read_type      = res.rtype;
  assign read_value     = res.rvalue;
  assign read_time      = res.rtime;
  assign read_quality   = res.rquality;
  assign read_only_flag = res.ro;
  assign timeouts_found = res.found;
  assign total_writes   = res.writes;

endmodule

`default_nettype wire

FILE: tb/tb_point_table_with_staleness_sweep.sv
`timescale 1ns / 1ps

// one result transfer as seen on the result ports
typedef struct packed {
  logic [1:0]  status;
  logic [1:0]  rtype;
  logic [63:0] rvalue;
  logic [63:0] rtime;
  logic [1:0]  rquality;
  logic        ro;
  logic [10:0] found;
  logic [31:0] writes;
} point_result_t;

class point_table_predictor;
  // shadow copy of the table and registers
  logic [1:0]    kind_mem    [pts_pkg::POINTS];
  logic [63:0]   word_mem    [pts_pkg::POINTS];
  logic [63:0]   stamp_mem   [pts_pkg::POINTS];
  logic [1:0]    quality_mem [pts_pkg::POINTS];
  logic          locked_mem  [pts_pkg::POINTS];
  bit            kind_known  [pts_pkg::POINTS];
  bit            word_known  [pts_pkg::POINTS];
  logic [10:0]   piu;
  logic [63:0]   max_age;
  logic [31:0]   write_count;
  point_result_t pending_results[$];
  int            errors;

  function new();
    for (int i = 0; i < pts_pkg::POINTS; i++) begin
      kind_mem[i]    = '0;
      word_mem[i]    = '0;
      stamp_mem[i]   = '0;
      quality_mem[i] = pts_pkg::Q_INITIAL;
      locked_mem[i]  = 1'b0;
      kind_known[i]  = 1'b0;
      word_known[i]  = 1'b0;
    end
    piu         = pts_pkg::PIU_RESET;
    max_age     = '0;
    write_count = '0;
    errors      = 0;
  endfunction

  function void set_reg(pts_pkg::cfg_reg_t idx, logic [63:0] data);
    if (idx == pts_pkg::REG_POINTS_IN_USE) begin
      piu = data[10:0];
    end else begin
      max_age = data;
    end
  endfunction

  // number of indices currently accepted
  function int limit();
    return (piu > pts_pkg::POINTS) ? pts_pkg::POINTS : int'(piu);
  endfunction

  // a read here never touches type or value that were never stored
  function bit readable(logic [9:0] idx);
    return kind_known[idx] && word_known[idx];
  endfunction

  // work out the result of one accepted request
  function void note_request(pts_pkg::req_t rq, logic [9:0] idx, logic [1:0] vt,
                             logic [63:0] w, logic ro, logic [63:0] now);
    point_result_t r;
    int lim;
    bit ok_idx;
    logic [10:0] hits;
    r = '0;
    lim = limit();
    ok_idx = int'(idx) < lim;
    hits = '0;
    case (rq)
      pts_pkg::REQ_WRITE: begin
        if (!ok_idx) begin
          r.status = pts_pkg::STS_BAD_INDEX;
        end else if (locked_mem[idx]) begin
          r.status = pts_pkg::STS_READ_ONLY;
        end else begin
          kind_mem[idx]   = vt;
          kind_known[idx] = 1'b1;
          if (vt != pts_pkg::VT_UNKNOWN) begin
            word_mem[idx]   = w;
            word_known[idx] = 1'b1;
          end
          stamp_mem[idx]   = now;
          quality_mem[idx] = pts_pkg::Q_GOOD;
          write_count++;
        end
      end
      pts_pkg::REQ_READ: begin
        if (!ok_idx) begin
          r.status = pts_pkg::STS_BAD_INDEX;
        end else begin
          r.rtype    = kind_mem[idx];
          r.rvalue   = word_mem[idx];
          r.rtime    = stamp_mem[idx];
          r.rquality = quality_mem[idx];
          r.ro       = locked_mem[idx];
        end
      end
      pts_pkg::REQ_SWEEP: begin
        // mark points older than the allowed age, skip zero stamps and future stamps
        if (max_age != 0 && now != 0) begin
          for (int i = 0; i < lim; i++) begin
            if (stamp_mem[i] != 0 && quality_mem[i] != pts_pkg::Q_TIMEOUT &&
                stamp_mem[i] < now && (now - stamp_mem[i]) > max_age) begin
              quality_mem[i] = pts_pkg::Q_TIMEOUT;
              hits++;
            end
          end
        end
        r.found = hits;
      end
      default: begin
        if (!ok_idx) begin
          r.status = pts_pkg::STS_BAD_INDEX;
        end else begin
          locked_mem[idx] = ro;
        end
      end
    endcase
    r.writes = write_count;
    pending_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      $error("%s expected %0h got %0h", name, want, seen);
      errors++;
    end
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_result(point_result_t got);
    point_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with nothing outstanding");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("read_type", 64'(want.rtype), 64'(got.rtype));
    compare_field("read_value", want.rvalue, got.rvalue);
    compare_field("read_time", want.rtime, got.rtime);
    compare_field("read_quality", 64'(want.rquality), 64'(got.rquality));
    compare_field("read_only_flag", 64'(want.ro), 64'(got.ro));
    compare_field("timeouts_found", 64'(want.found), 64'(got.found));
    compare_field("total_writes", 64'(want.writes), 64'(got.writes));
  endfunction
endclass

module tb_point_table_with_staleness_sweep;
  import pts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 250;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [9:0]  point_index;
  logic [1:0]  value_type;
  logic [63:0] value_word;
  logic        access_read_only;
  logic [63:0] current_time;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [1:0]  read_type;
  logic [63:0] read_value;
  logic [63:0] read_time;
  logic [1:0]  read_quality;
  logic        read_only_flag;
  logic [10:0] timeouts_found;
  logic [31:0] total_writes;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;

  point_table_predictor sb;
  int unsigned cycles;
  bit          no_idle;
  logic [63:0] clock_ns;

  point_table_with_staleness_sweep dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .point_index(point_index), .value_type(value_type),
    .value_word(value_word), .access_read_only(access_read_only),
    .current_time(current_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_type(read_type), .read_value(read_value),
    .read_time(read_time), .read_quality(read_quality),
    .read_only_flag(read_only_flag), .timeouts_found(timeouts_found),
    .total_writes(total_writes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result({status, read_type, read_value, read_time, read_quality,
                       read_only_flag, timeouts_found, total_writes});
    end
  end

  // receiver backpressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // one register write on the config channel
  task automatic write_reg(cfg_reg_t idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // present one request and hold it until the transfer
  task automatic send_req(req_t rq, logic [9:0] idx, logic [1:0] vt, logic [63:0] w,
                          logic ro, logic [63:0] now);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid         = 1'b1;
    req_type         = rq;
    point_index      = idx;
    value_type       = vt;
    value_word       = w;
    access_read_only = ro;
    current_time     = now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rq, idx, vt, w, ro, now);
  endtask

  // drop the request and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // random request, mostly in range and on a slowly advancing clock
  task automatic random_req(int sweep_pct);
    req_t        rq;
    logic [9:0]  idx;
    logic [1:0]  vt;
    logic [63:0] now;
    logic        ro;
    int          lim;
    int          pick;
    int          tsel;
    lim  = sb.limit();
    pick = $urandom_range(0, 99);
    if (pick < sweep_pct) begin
      rq = REQ_SWEEP;
    end else if (pick < 50) begin
      rq = REQ_WRITE;
    end else if (pick < 82) begin
      rq = REQ_READ;
    end else begin
      rq = REQ_ACCESS;
    end
    if (lim > 0 && $urandom_range(0, 9) != 0) begin
      idx = 10'($urandom_range(0, lim - 1));
    end else begin
      idx = 10'($urandom);
    end
    if (rq == REQ_READ && int'(idx) < lim && !sb.readable(idx)) rq = REQ_WRITE;
    vt = ($urandom_range(0, 9) == 0) ? VT_UNKNOWN : 2'($urandom_range(0, 2));
    ro = (rq == REQ_ACCESS) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
    clock_ns += 64'($urandom_range(0, 60));
    tsel = $urandom_range(0, 49);
    case (tsel)
      0:       now = '0;
      1:       now = '1;
      2, 3:    now = {$urandom, $urandom};
      default: now = clock_ns;
    endcase
    send_req(rq, idx, vt, {$urandom, $urandom}, ro, now);
  endtask

  initial begin
    logic [10:0] piu_list   [PHASES];
    logic [63:0] age_list   [PHASES];
    int          sweep_list [PHASES];
    piu_list = '{11'd16, 11'd1, 11'd2047, 11'd0, 11'd5, 11'd1024, 11'd64, 11'd32};
    age_list = '{64'd300, 64'd1, '1, 64'd50, 64'd0, 64'd1000,
                 {$urandom, $urandom}, 64'd100};
    sweep_list = '{10, 10, 3, 10, 10, 3, 8, 10};

    sb               = new();
    clk              = 1'b0;
    rst              = 1'b1;
    in_valid         = 1'b0;
    req_type         = REQ_WRITE;
    point_index      = '0;
    value_type       = '0;
    value_word       = '0;
    access_read_only = 1'b0;
    current_time     = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_POINTS_IN_USE;
    cfg_data         = '0;
    cycles           = 0;
    no_idle          = 1'b0;
    clock_ns         = 64'd100;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: four points, short allowed age
    write_reg(REG_POINTS_IN_USE, 64'd4);
    write_reg(REG_TIMEOUT_LIMIT, 64'd100);
    send_req(REQ_WRITE, 10'd0, 2'd0, '1, 1'b0, 64'd1000);
    // stamp of zero looks never written to a sweep
    send_req(REQ_WRITE, 10'd1, 2'd1, '0, 1'b1, 64'd0);
    send_req(REQ_WRITE, 10'd2, 2'd2, 64'h8000_0000_0000_0001, 1'b0, 64'd5000);
    send_req(REQ_WRITE, 10'd3, 2'd2, 64'h0123_4567_89ab_cdef, 1'b1, 64'd2000);
    // unknown type keeps the old value
    send_req(REQ_WRITE, 10'd3, VT_UNKNOWN, '1, 1'b0, 64'd1500);
    send_req(REQ_READ, 10'd3, 2'd0, '0, 1'b0, 64'd1600);
    send_req(REQ_READ, 10'd1, 2'd3, '1, 1'b1, 64'd1700);
    // out of range on every indexed request
    send_req(REQ_WRITE, 10'd1023, 2'd1, '1, 1'b0, '1);
    send_req(REQ_READ, 10'd4, 2'd0, '0, 1'b0, 64'd1800);
    send_req(REQ_ACCESS, 10'd1023, 2'd0, '0, 1'b1, 64'd1900);
    // read-only point rejects writes
    send_req(REQ_ACCESS, 10'd0, 2'd0, '0, 1'b1, 64'd2000);
    send_req(REQ_WRITE, 10'd0, 2'd2, 64'h5555_aaaa_5555_aaaa, 1'b0, 64'd2100);
    send_req(REQ_READ, 10'd0, 2'd0, '0, 1'b0, 64'd2200);
    // sweep at time zero does nothing, then stale points, then nothing new
    send_req(REQ_SWEEP, 10'd0, 2'd0, '0, 1'b0, 64'd0);
    send_req(REQ_SWEEP, 10'd0, 2'd0, '0, 1'b0, 64'd4000);
    send_req(REQ_SWEEP, 10'd2, 2'd0, '0, 1'b0, 64'd4000);
    send_req(REQ_READ, 10'd0, 2'd0, '0, 1'b0, 64'd4100);
    send_req(REQ_ACCESS, 10'd0, 2'd0, '0, 1'b0, 64'd4200);
    send_req(REQ_WRITE, 10'd0, 2'd2, 64'hdead_beef_0bad_f00d, 1'b0, '1);
    send_req(REQ_READ, 10'd0, 2'd0, '0, 1'b0, 64'd4300);
    // latest stamp equals the sweep time and is skipped, point 2 now times out
    send_req(REQ_SWEEP, 10'd0, 2'd0, '0, 1'b0, '1);

    // random phases, one setting of both registers each, no idling in the last one
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(REG_POINTS_IN_USE, 64'(piu_list[ph]));
      write_reg(REG_TIMEOUT_LIMIT, age_list[ph]);
      no_idle = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) random_req(sweep_list[ph]);
    end

    settle();
    repeat (32) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/pts_pkg.sv
rtl/core/pts_ram.sv
rtl/core/pts_engine.sv
rtl/core/point_table_with_staleness_sweep.sv
tb/tb_point_table_with_staleness_sweep.sv
